### design/rdq_pkg.sv
// Package for the reversible deque: depth, widths, command and status codes,
// and the beat and cell control types. No dependencies.
package rdq_pkg;

  localparam int DEPTH = 1024;
  localparam int LO_W  = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] CMD_POP_BACK   = 3'd0;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd1;
  localparam logic [2:0] CMD_REVERSE    = 3'd2;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd3;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] push_value;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } res_beat_t;

  typedef struct packed {
    logic            shift_left;
    logic            shift_right;
    logic            load;
    logic [LO_W-1:0] load_idx;
    logic [31:0]     value;
  } cell_ctrl_t;

endpackage

### design/rdq_cell.sv
// One storage cell of the deque chain: holds a word and takes a neighbor's
// word on a shift or the broadcast word on a load. Depends on rdq_pkg.
module rdq_cell import rdq_pkg::*; (
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic        sel,
  input  logic [31:0] left_in,
  input  logic [31:0] right_in,
  output logic [31:0] data
);

  always_ff @(posedge clk) begin
    if (sel) begin
      data <= ctrl.value;
    end else if (ctrl.shift_left) begin
      data <= right_in;
    end else if (ctrl.shift_right) begin
      data <= left_in;
    end
  end

endmodule

### design/rdq_ctrl.sv
// Controller of the deque: tracks the occupied span of the cell chain and the
// orientation, drives the chain and owns the result register. Depends on rdq_pkg.
module rdq_ctrl import rdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_beat_t   cmd_beat,
  output logic        res_valid,
  input  logic        res_stall,
  output res_beat_t   res_beat,
  input  logic [31:0] front_word,
  input  logic [31:0] back_word,
  output cell_ctrl_t  cell_ctrl
);

  logic             busy;
  logic             busy_next;
  cmd_beat_t        held;
  logic [LO_W-1:0]  lo;
  logic [LO_W-1:0]  lo_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             reversed;
  logic             reversed_next;
  cmd_beat_t        op;
  logic             active;
  logic             out_free;
  logic             done;
  logic             emit;
  res_beat_t        emit_beat;
  logic             phys_back;
  logic [SUM_W-1:0] back_end;

  assign cmd_stall = busy;
  assign op        = busy ? held : cmd_beat;
  assign active    = busy | cmd_valid;
  assign out_free  = !res_valid | !res_stall;
  assign back_end  = SUM_W'(lo) + SUM_W'(count);

  always_comb begin
    done          = 1'b0;
    emit          = 1'b0;
    emit_beat     = '0;
    lo_next       = lo;
    count_next    = count;
    reversed_next = reversed;
    cell_ctrl     = '0;
    cell_ctrl.value = op.push_value;
    phys_back     = (op.command == CMD_POP_BACK || op.command == CMD_PUSH_BACK) ?
                    !reversed : reversed;
    if (active) begin
      case (op.command)
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (count == '0) begin
            if (out_free) begin
              emit             = 1'b1;
              emit_beat.status = ST_EMPTY;
              done             = 1'b1;
            end
          end else if (phys_back) begin
            if (back_end == SUM_W'(DEPTH)) begin
              if (out_free) begin
                emit                = 1'b1;
                emit_beat.pop_value = back_word;
                emit_beat.status    = ST_OK;
                count_next          = count - 1'b1;
                done                = 1'b1;
              end
            end else begin
              cell_ctrl.shift_right = 1'b1;
              lo_next               = lo + 1'b1;
            end
          end else begin
            if (lo == '0) begin
              if (out_free) begin
                emit                = 1'b1;
                emit_beat.pop_value = front_word;
                emit_beat.status    = ST_OK;
                lo_next             = LO_W'(1);
                count_next          = count - 1'b1;
                done                = 1'b1;
              end
            end else begin
              cell_ctrl.shift_left = 1'b1;
              lo_next              = lo - 1'b1;
            end
          end
        end
        CMD_REVERSE: begin
          reversed_next = !reversed;
          done          = 1'b1;
        end
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (count == CNT_W'(DEPTH)) begin
            if (out_free) begin
              emit             = 1'b1;
              emit_beat.status = ST_FULL;
              done             = 1'b1;
            end
          end else if (phys_back) begin
            if (back_end == SUM_W'(DEPTH)) begin
              cell_ctrl.shift_left = 1'b1;
              lo_next              = lo - 1'b1;
            end else begin
              cell_ctrl.load     = 1'b1;
              cell_ctrl.load_idx = back_end[LO_W-1:0];
            end
            count_next = count + 1'b1;
            done       = 1'b1;
          end else begin
            if (lo == '0) begin
              cell_ctrl.shift_right = 1'b1;
            end else begin
              cell_ctrl.load     = 1'b1;
              cell_ctrl.load_idx = lo - 1'b1;
              lo_next            = lo - 1'b1;
            end
            count_next = count + 1'b1;
            done       = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    busy_next = active & !done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      lo        <= '0;
      count     <= '0;
      reversed  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      lo        <= lo_next;
      count     <= count_next;
      reversed  <= reversed_next;
      res_valid <= emit | (res_valid & res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      held <= cmd_beat;
    end
    if (emit) begin
      res_beat <= emit_beat;
    end
  end

endmodule

### design/reversible_deque.sv
// Reversible deque top level: a chain of DEPTH word cells and its controller.
// A push, a reverse, an ignored command, or a pop at an end that sits at the
// edge of the chain waits on nothing but a stalled result channel; a pop result
// is registered. Otherwise a pop first slides the chain one cell per cycle
// toward that edge. Reset clears the controller; cell words are undefined until
// written. Depends on rdq_pkg, rdq_cell and rdq_ctrl.
module reversible_deque import rdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_beat_t cmd_beat,
  output logic      res_valid,
  input  logic      res_stall,
  output res_beat_t res_beat
);

  cell_ctrl_t  cell_ctrl;
  logic [31:0] cell_data [DEPTH];

  rdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_beat   (cmd_beat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat),
    .front_word (cell_data[0]),
    .back_word  (cell_data[DEPTH-1]),
    .cell_ctrl  (cell_ctrl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_in;
    logic [31:0] right_in;
    logic        sel;

    assign left_in  = (i == 0) ? cell_ctrl.value : cell_data[(i == 0) ? 0 : i - 1];
    assign right_in = (i == DEPTH - 1) ? cell_ctrl.value :
                      cell_data[(i == DEPTH - 1) ? DEPTH - 1 : i + 1];
    assign sel      = cell_ctrl.load && (cell_ctrl.load_idx == LO_W'(i));

    rdq_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .sel      (sel),
      .left_in  (left_in),
      .right_in (right_in),
      .data     (cell_data[i])
    );
  end

`ifndef ASSERT_OFF
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(cell_ctrl.shift_left && cell_ctrl.shift_right))
    else $error("Chain shifts both ways at once.");

  a_load_alone: assert property (@(posedge clk) disable iff (rst)
    cell_ctrl.load |-> !cell_ctrl.shift_left && !cell_ctrl.shift_right)
    else $error("Cell load coincides with a chain shift.");

  a_shift_has_work: assert property (@(posedge clk) disable iff (rst)
    (cell_ctrl.shift_left || cell_ctrl.shift_right || cell_ctrl.load) |->
    (cmd_stall || cmd_valid))
    else $error("Chain moves with no command beat in hand.");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_beat.status != ST_OK) |-> res_beat.pop_value == 32'sd0)
    else $error("Failed beat carries a nonzero word.");
`endif

endmodule

### tb/deque_checker.sv
`timescale 1ns / 1ps
// Checker for the reversible deque: watches the command and result channels,
// keeps its own copy of the ring, orientation and count, and compares results.
// Depends on rdq_pkg for the depth, beat types, command codes and status codes.
module deque_checker import rdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_stall,
  input  cmd_beat_t cmd_beat,
  input  logic      res_valid,
  input  logic      res_stall,
  input  res_beat_t res_beat,
  output int        pending,
  output int        errors
);

  logic [31:0] slots [DEPTH];
  int unsigned front_idx;
  int unsigned held;
  logic        flipped;
  res_beat_t   expected_pops [$];
  res_beat_t   predicted;
  res_beat_t   wanted;
  int          mismatches;

  function automatic bit deque_apply(input cmd_beat_t beat, output res_beat_t res);
    logic            at_tail;
    logic [LO_W-1:0] slot;
    res = '0;
    case (beat.command)
      CMD_POP_BACK, CMD_POP_FRONT: begin
        at_tail = (beat.command == CMD_POP_BACK) ^ flipped;
        if (held == 0) begin
          res.status = ST_EMPTY;
          return 1'b1;
        end
        if (at_tail) begin
          slot = LO_W'((front_idx + held - 1) % DEPTH);
          res.pop_value = slots[slot];
        end else begin
          slot = LO_W'(front_idx);
          res.pop_value = slots[slot];
          front_idx = (front_idx + 1) % DEPTH;
        end
        res.status = ST_OK;
        held--;
        return 1'b1;
      end
      CMD_REVERSE: begin
        flipped = ~flipped;
        return 1'b0;
      end
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        at_tail = (beat.command == CMD_PUSH_BACK) ^ flipped;
        if (held >= DEPTH) begin
          res.status = ST_FULL;
          return 1'b1;
        end
        if (at_tail) begin
          slot = LO_W'((front_idx + held) % DEPTH);
          slots[slot] = beat.push_value;
        end else begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          slot = LO_W'(front_idx);
          slots[slot] = beat.push_value;
        end
        held++;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      front_idx = 0;
      held = 0;
      flipped = 1'b0;
      expected_pops.delete();
      mismatches = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_pops.size() == 0) begin
          $error("result beat with nothing expected: pop_value %0d, status %0d",
                 res_beat.pop_value, res_beat.status);
          mismatches++;
        end else begin
          wanted = expected_pops[0];
          expected_pops.delete(0);
          if (res_beat.pop_value !== wanted.pop_value) begin
            $error("pop_value: expected %0d, got %0d", wanted.pop_value, res_beat.pop_value);
            mismatches++;
          end
          if (res_beat.status !== wanted.status) begin
            $error("status: expected %0d, got %0d", wanted.status, res_beat.status);
            mismatches++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        if (deque_apply(cmd_beat, predicted)) begin
          expected_pops.insert(expected_pops.size(), predicted);
        end
      end
    end
    pending <= expected_pops.size();
    errors <= mismatches;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the reversible deque testbench: clock, reset, command stimulus with
// random gaps, random result stalls and the verdict. Depends on rdq_pkg,
// reversible_deque and deque_checker.
module tb_top;
  import rdq_pkg::*;

  localparam int LIMIT = 4 * 1600 * (DEPTH + 130);

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_beat_t cmd_beat = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_beat_t res_beat;

  int pending;
  int errors;
  int cycle_count = 0;
  int fill_level = 0;
  int quiet_left = 0;
  int stall_run = 0;
  int stall_pick;
  logic stall_hold = 1'b0;
  int counted;

  always #1 clk = ~clk;

  reversible_deque DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_beat  (cmd_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat)
  );

  deque_checker pop_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_beat  (cmd_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat),
    .pending   (pending),
    .errors    (errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 10) begin
        stall_hold = 1'b0;
        stall_run = $urandom_range(100, 300);
      end else if (stall_pick < 55) begin
        stall_hold = 1'b0;
        stall_run = $urandom_range(1, 6);
      end else if (stall_pick < 95) begin
        stall_hold = 1'b1;
        stall_run = $urandom_range(1, 3);
      end else begin
        stall_hold = 1'b1;
        stall_run = $urandom_range(20, 60);
      end
    end else begin
      stall_run--;
    end
    res_stall <= stall_hold;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(50, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input logic [2:0] code, input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_beat <= '{command: code, push_value: word};
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    case (code)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: if (fill_level < DEPTH) fill_level++;
      CMD_POP_BACK, CMD_POP_FRONT: if (fill_level > 0) fill_level--;
      default: ;
    endcase
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      send_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word());
    end else if (r < push_pct + pop_pct) begin
      send_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_word());
    end else if (r < 96) begin
      send_cmd(CMD_REVERSE, pick_word());
    end else begin
      case ($urandom_range(0, 2))
        0: send_cmd(CMD_SPARE_A, pick_word());
        1: send_cmd(CMD_SPARE_B, pick_word());
        default: send_cmd(CMD_SPARE_C, pick_word());
      endcase
      return;
    end
    counted++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(CMD_POP_BACK, 32'h0000_0000);
    send_cmd(CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_cmd(CMD_REVERSE, 32'h0000_0000);
    send_cmd(CMD_REVERSE, 32'h0000_0000);
    send_cmd(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_BACK, 32'h0000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_cmd(CMD_POP_BACK, 32'h0000_0000);
    send_cmd(CMD_POP_FRONT, 32'h0000_0000);
    send_cmd(CMD_REVERSE, 32'h0000_0000);
    send_cmd(CMD_POP_BACK, 32'h0000_0000);
    send_cmd(CMD_POP_FRONT, 32'h0000_0000);
    send_cmd(CMD_POP_FRONT, 32'h0000_0000);
    send_cmd(CMD_SPARE_A, 32'h1234_5678);
    send_cmd(CMD_SPARE_B, 32'hFFFF_FFFF);
    send_cmd(CMD_SPARE_C, 32'h8000_0000);
    send_cmd(CMD_REVERSE, 32'h0000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0001);
    send_cmd(CMD_PUSH_BACK, 32'h0000_0002);
    send_cmd(CMD_POP_FRONT, 32'h0000_0000);
    send_cmd(CMD_POP_BACK, 32'h0000_0000);
    send_cmd(CMD_POP_BACK, 32'h0000_0000);
    wait_for_results();

    counted = 0;
    while (counted < 300) send_random(48, 40);
    wait_for_results();

    while (fill_level < DEPTH) send_random(90, 5);
    repeat (4) begin
      send_cmd(CMD_PUSH_BACK, pick_word());
      send_cmd(CMD_PUSH_FRONT, pick_word());
      send_cmd(CMD_REVERSE, pick_word());
    end
    counted = 0;
    while (counted < 40) send_random(45, 50);
    while (fill_level < DEPTH) send_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                                        pick_word());
    send_cmd(CMD_PUSH_FRONT, pick_word());
    send_cmd(CMD_PUSH_BACK, pick_word());

    wait_for_results();
    repeat (DEPTH + 16) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
